// File: hw/rtl/radar_pulse_pair_dwell_accumulator_defines.svh
// Assertion macros for the pulse-pair dwell accumulator checker.
`ifndef RADAR_PULSE_PAIR_DWELL_ACCUMULATOR_DEFINES_SVH
`define RADAR_PULSE_PAIR_DWELL_ACCUMULATOR_DEFINES_SVH

// Antecedent implies consequent in the next cycle, outside reset.
`define RPPDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rppda: next-cycle check failed");

// Antecedent implies consequent in the same cycle, outside reset.
`define RPPDA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rppda: same-cycle check failed");

// Antecedent implies consequent in the next cycle, reset included.
`define RPPDA_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("rppda: reset check failed");

`endif

// File: hw/rtl/rppda_pkg.sv
// Shared types, constants and helpers of the pulse-pair dwell accumulator.
package rppda_pkg;

    localparam int MAX_GATES   = 1024;
    localparam int GATE_W      = 10;
    localparam int GATE_AW     = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
    localparam int SAMPLE_W    = 16;
    localparam int MULT_W      = 2 * SAMPLE_W;
    localparam int PROD_W      = MULT_W + 2;
    localparam int SUM_W       = 44;
    localparam int N_SUMS      = 8;
    localparam int SINGLE_SUMS = 3;
    localparam int STOKES_SUMS = 4;

    typedef enum logic [1:0] {
        MODE_SINGLE = 2'b00,
        MODE_DUAL   = 2'b01,
        MODE_STOKES = 2'b10
    } mode_t;

    typedef struct packed {
        logic [GATE_W-1:0]          gate;
        logic                       first_hit;
        logic                       last_hit;
        logic signed [SAMPLE_W-1:0] h_i;
        logic signed [SAMPLE_W-1:0] h_q;
        logic signed [SAMPLE_W-1:0] v_i;
        logic signed [SAMPLE_W-1:0] v_q;
        logic signed [SAMPLE_W-1:0] h_i_prev;
        logic signed [SAMPLE_W-1:0] h_q_prev;
        logic signed [SAMPLE_W-1:0] v_i_prev;
        logic signed [SAMPLE_W-1:0] v_q_prev;
    } in_t;

    typedef struct packed {
        logic [GATE_W-1:0]       gate_out;
        logic signed [SUM_W-1:0] sum0;
        logic signed [SUM_W-1:0] sum1;
        logic signed [SUM_W-1:0] sum2;
        logic signed [SUM_W-1:0] sum3;
        logic signed [SUM_W-1:0] sum4;
        logic signed [SUM_W-1:0] sum5;
        logic signed [SUM_W-1:0] sum6;
        logic signed [SUM_W-1:0] sum7;
    } out_t;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        mode_t             mode;
        logic [GATE_W-1:0] gate;
    } ctl_t;

    typedef struct packed {
        logic signed [MULT_W-1:0] hh_i;
        logic signed [MULT_W-1:0] hh_q;
        logic signed [MULT_W-1:0] vv_i;
        logic signed [MULT_W-1:0] vv_q;
        logic signed [MULT_W-1:0] ha_i;
        logic signed [MULT_W-1:0] ha_q;
        logic signed [MULT_W-1:0] hb_1;
        logic signed [MULT_W-1:0] hb_2;
        logic signed [MULT_W-1:0] va_i;
        logic signed [MULT_W-1:0] va_q;
        logic signed [MULT_W-1:0] vb_1;
        logic signed [MULT_W-1:0] vb_2;
        logic signed [MULT_W-1:0] xr_1;
        logic signed [MULT_W-1:0] xr_2;
        logic signed [MULT_W-1:0] xi_1;
        logic signed [MULT_W-1:0] xi_2;
    } mult_t;

    typedef logic [N_SUMS-1:0][PROD_W-1:0] prod_row_t;
    typedef logic [N_SUMS-1:0][SUM_W-1:0]  row_t;

    function automatic logic sum_used(mode_t m, int unsigned k);
        logic used;
        unique case (m)
            MODE_SINGLE: used = (k < SINGLE_SUMS);
            MODE_DUAL:   used = 1'b1;
            MODE_STOKES: used = (k < STOKES_SUMS);
            default:     used = 1'b0;
        endcase
        return used;
    endfunction

endpackage

// File: hw/rtl/rppda_prod.sv
// Product stages: sixteen sample multiplies, then per-mode combination into up to eight terms.
module rppda_prod (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  rppda_pkg::ctl_t       in_ctl,
    input  rppda_pkg::in_t        in_data,
    output rppda_pkg::ctl_t       out_ctl,
    output rppda_pkg::prod_row_t  out_prod
);
    import rppda_pkg::*;

    ctl_t      s1_ctl_reg;
    ctl_t      s2_ctl_reg;
    mult_t     mult_reg;
    prod_row_t prod_reg;
    prod_row_t prod_next;

    logic signed [PROD_W-1:0] hp, vp, ha, hb, va, vb, xr, xi, sv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end else if (en) begin
            s1_ctl_reg <= in_ctl;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mult_reg.hh_i <= MULT_W'(in_data.h_i) * MULT_W'(in_data.h_i);
            mult_reg.hh_q <= MULT_W'(in_data.h_q) * MULT_W'(in_data.h_q);
            mult_reg.vv_i <= MULT_W'(in_data.v_i) * MULT_W'(in_data.v_i);
            mult_reg.vv_q <= MULT_W'(in_data.v_q) * MULT_W'(in_data.v_q);
            mult_reg.ha_i <= MULT_W'(in_data.h_i_prev) * MULT_W'(in_data.h_i);
            mult_reg.ha_q <= MULT_W'(in_data.h_q_prev) * MULT_W'(in_data.h_q);
            mult_reg.hb_1 <= MULT_W'(in_data.h_i_prev) * MULT_W'(in_data.h_q);
            mult_reg.hb_2 <= MULT_W'(in_data.h_q_prev) * MULT_W'(in_data.h_i);
            mult_reg.va_i <= MULT_W'(in_data.v_i_prev) * MULT_W'(in_data.v_i);
            mult_reg.va_q <= MULT_W'(in_data.v_q_prev) * MULT_W'(in_data.v_q);
            mult_reg.vb_1 <= MULT_W'(in_data.v_i_prev) * MULT_W'(in_data.v_q);
            mult_reg.vb_2 <= MULT_W'(in_data.v_q_prev) * MULT_W'(in_data.v_i);
            mult_reg.xr_1 <= MULT_W'(in_data.v_i) * MULT_W'(in_data.h_i);
            mult_reg.xr_2 <= MULT_W'(in_data.v_q) * MULT_W'(in_data.h_q);
            mult_reg.xi_1 <= MULT_W'(in_data.v_q) * MULT_W'(in_data.h_i);
            mult_reg.xi_2 <= MULT_W'(in_data.v_i) * MULT_W'(in_data.h_q);
            prod_reg      <= prod_next;
        end
    end

    assign hp = PROD_W'(mult_reg.hh_i) + PROD_W'(mult_reg.hh_q);
    assign vp = PROD_W'(mult_reg.vv_i) + PROD_W'(mult_reg.vv_q);
    assign ha = PROD_W'(mult_reg.ha_i) + PROD_W'(mult_reg.ha_q);
    assign hb = PROD_W'(mult_reg.hb_1) - PROD_W'(mult_reg.hb_2);
    assign va = PROD_W'(mult_reg.va_i) + PROD_W'(mult_reg.va_q);
    assign vb = PROD_W'(mult_reg.vb_1) - PROD_W'(mult_reg.vb_2);
    assign xr = PROD_W'(mult_reg.xr_1) + PROD_W'(mult_reg.xr_2);
    assign xi = PROD_W'(mult_reg.xi_1) - PROD_W'(mult_reg.xi_2);
    assign sv = PROD_W'(mult_reg.xi_2) - PROD_W'(mult_reg.xi_1);

    always_comb begin
        prod_next = '0;
        unique case (s1_ctl_reg.mode)
            MODE_SINGLE: begin
                prod_next[0] = ha;
                prod_next[1] = hb;
                prod_next[2] = hp;
            end
            MODE_DUAL: begin
                prod_next[0] = va;
                prod_next[1] = vb;
                prod_next[2] = vp;
                prod_next[3] = ha;
                prod_next[4] = hb;
                prod_next[5] = hp;
                prod_next[6] = xr;
                prod_next[7] = xi;
            end
            MODE_STOKES: begin
                prod_next[0] = hp;
                prod_next[1] = vp;
                prod_next[2] = xr <<< 1;
                prod_next[3] = sv <<< 1;
            end
            default: begin
                prod_next = '0;
            end
        endcase
    end

    assign out_ctl  = s2_ctl_reg;
    assign out_prod = prod_reg;

endmodule

// File: hw/rtl/rppda_store.sv
// Per-gate sum memory with read-modify-write, write-back forwarding and saturation.
module rppda_store (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  rppda_pkg::ctl_t       in_ctl,
    input  rppda_pkg::prod_row_t  in_prod,
    output rppda_pkg::ctl_t       out_ctl,
    output rppda_pkg::row_t       out_row
);
    import rppda_pkg::*;

    row_t              mem [MAX_GATES];
    row_t              rd_reg;
    ctl_t              r_ctl_reg;
    ctl_t              a_ctl_reg;
    prod_row_t         r_prod_reg;
    prod_row_t         a_prod_reg;
    row_t              a_old_reg;
    logic              wb_valid_reg;
    logic [GATE_W-1:0] wb_gate_reg;
    row_t              wb_row_reg;

    logic [GATE_AW-1:0] rd_addr;
    logic [GATE_AW-1:0] wr_addr;
    row_t               r_old;
    row_t               a_old;
    row_t               new_row;

    function automatic logic [SUM_W-1:0] sat_sum(logic signed [SUM_W:0] v);
        logic [SUM_W-1:0] res;
        if (v[SUM_W] != v[SUM_W-1]) begin
            res = {v[SUM_W], {(SUM_W-1){~v[SUM_W]}}};
        end else begin
            res = v[SUM_W-1:0];
        end
        return res;
    endfunction

    assign rd_addr = GATE_AW'(in_ctl.gate);
    assign wr_addr = GATE_AW'(a_ctl_reg.gate);

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_reg <= mem[rd_addr];
            if (a_ctl_reg.valid) begin
                mem[wr_addr] <= new_row;
            end
        end
    end

    // take the row last written when it belongs to the same gate
    assign r_old = (wb_valid_reg && (wb_gate_reg == r_ctl_reg.gate)) ? wb_row_reg : rd_reg;
    assign a_old = (wb_valid_reg && (wb_gate_reg == a_ctl_reg.gate)) ? wb_row_reg : a_old_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_ctl_reg    <= '0;
            a_ctl_reg    <= '0;
            wb_valid_reg <= 1'b0;
        end else if (en) begin
            r_ctl_reg    <= in_ctl;
            a_ctl_reg    <= r_ctl_reg;
            wb_valid_reg <= a_ctl_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_prod_reg  <= in_prod;
            a_prod_reg  <= r_prod_reg;
            a_old_reg   <= r_old;
            wb_gate_reg <= a_ctl_reg.gate;
            wb_row_reg  <= new_row;
        end
    end

    always_comb begin
        logic signed [SUM_W:0] acc;
        new_row = '0;
        for (int k = 0; k < N_SUMS; k++) begin
            acc = (SUM_W+1)'($signed(a_old[k])) + (SUM_W+1)'($signed(a_prod_reg[k]));
            if (a_ctl_reg.first) begin
                new_row[k] = SUM_W'($signed(a_prod_reg[k]));
            end else begin
                new_row[k] = sat_sum(acc);
            end
        end
    end

    assign out_ctl = a_ctl_reg;
    assign out_row = new_row;

endmodule

// File: hw/rtl/radar_pulse_pair_dwell_accumulator.sv
// Top level of the dual-polarization pulse-pair dwell accumulator.
//
// Input channel s_valid/s_ready/s_payload carries one range gate of one hit:
// current and previous-hit H and V IQ samples plus first/last hit flags.
// Result channel m_valid/m_ready/m_payload carries a gate's eight sums on its
// last hit; items that are not last hits give no transaction.
// cfg_wr_en/cfg_wr_data write the mode register (0 single-pol, 1 dual-pol,
// 2 Stokes); change it only while no transaction is in flight.
// An item passes the product, store read and store accumulate registers, then the output register.
// Throughput: one item per cycle while s_ready is high; the per-gate memory does one read and one
// write-back each cycle, with back-to-back hits on a gate forwarded.
// Items with mode 3 or a gate beyond the memory are dropped.
// Reset (aresetn low, synchronous) empties the pipeline and sets mode 0; the
// gate memory is not cleared, so each gate must start with a first hit.
// When the receiver stalls, the output register holds its result and the
// pipeline keeps accepting until a last-hit item reaches the write-back
// stage; then s_ready falls until m_ready returns.
module radar_pulse_pair_dwell_accumulator (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rppda_pkg::in_t   s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output rppda_pkg::out_t  m_payload,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_wr_data
);
    import rppda_pkg::*;

    mode_t     mode_reg;
    logic      m_valid_reg;
    out_t      m_payload_reg;
    out_t      m_payload_next;

    ctl_t      in_ctl;
    ctl_t      p_ctl;
    prod_row_t p_prod;
    ctl_t      a_ctl;
    row_t      a_row;
    logic      en;
    logic      load;
    logic      mode_ok;
    logic      gate_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_SINGLE;
        end else if (cfg_wr_en) begin
            mode_reg <= mode_t'(cfg_wr_data);
        end
    end

    assign en   = !m_valid_reg || m_ready || !(a_ctl.valid && a_ctl.last);
    assign load = en && a_ctl.valid && a_ctl.last;

    assign mode_ok = (mode_reg == MODE_SINGLE) || (mode_reg == MODE_DUAL)
                  || (mode_reg == MODE_STOKES);
    assign gate_ok = (32'(s_payload.gate) < MAX_GATES);

    always_comb begin
        in_ctl.valid = s_valid && en && mode_ok && gate_ok;
        in_ctl.first = s_payload.first_hit;
        in_ctl.last  = s_payload.last_hit;
        in_ctl.mode  = mode_reg;
        in_ctl.gate  = s_payload.gate;
    end

    rppda_prod u_prod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctl   (in_ctl),
        .in_data  (s_payload),
        .out_ctl  (p_ctl),
        .out_prod (p_prod)
    );

    rppda_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctl   (p_ctl),
        .in_prod  (p_prod),
        .out_ctl  (a_ctl),
        .out_row  (a_row)
    );

    // zero the sums the hit's mode does not produce
    always_comb begin
        m_payload_next.gate_out = a_ctl.gate;
        m_payload_next.sum0 = sum_used(a_ctl.mode, 0) ? a_row[0] : '0;
        m_payload_next.sum1 = sum_used(a_ctl.mode, 1) ? a_row[1] : '0;
        m_payload_next.sum2 = sum_used(a_ctl.mode, 2) ? a_row[2] : '0;
        m_payload_next.sum3 = sum_used(a_ctl.mode, 3) ? a_row[3] : '0;
        m_payload_next.sum4 = sum_used(a_ctl.mode, 4) ? a_row[4] : '0;
        m_payload_next.sum5 = sum_used(a_ctl.mode, 5) ? a_row[5] : '0;
        m_payload_next.sum6 = sum_used(a_ctl.mode, 6) ? a_row[6] : '0;
        m_payload_next.sum7 = sum_used(a_ctl.mode, 7) ? a_row[7] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign s_ready   = en;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// File: hw/rtl/rppda_checker.sv
// Port-level checker for the pulse-pair dwell accumulator, bound to the top level.
`include "radar_pulse_pair_dwell_accumulator_defines.svh"

module rppda_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input rppda_pkg::out_t  m_payload
);
    import rppda_pkg::*;

    `RPPDA_ASSERT_NEXT(hold_result, m_valid && !m_ready, m_valid && $stable(m_payload))
    `RPPDA_ASSERT_NOW(ready_when_free, !m_valid || m_ready, s_ready)
    `RPPDA_ASSERT_ALWAYS(clear_on_reset, !aresetn, !m_valid)
    `RPPDA_ASSERT_NEXT(stall_only_when_full, !s_ready, m_valid || s_ready)

endmodule

bind radar_pulse_pair_dwell_accumulator rppda_checker u_rppda_checker (.*);
